// ===== src/assert_macros.svh =====
// Assertion helpers for the RTL. Clock and reset are the block's own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition never true on a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== src/pbs_pkg.sv =====
`default_nettype none

package pbs_pkg;

  // Ring geometry. RING_BLOCKS and SUBS_PER_BLOCK are powers of two.
  localparam int RING_BLOCKS       = 4;
  localparam int SUBS_PER_BLOCK    = 4;
  localparam int PACKETS_PER_BLOCK = 64;

  localparam int SEQ_W      = 48;
  localparam int ENG_W      = 8;
  localparam int JUMP_W     = 16;
  localparam int RUN_W      = 8;
  localparam int MISS_W     = 32;
  localparam int CNT_W      = 11;
  localparam int IDX_OUT_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam int BLK_W       = $clog2(RING_BLOCKS);
  localparam int SUB_SH      = $clog2(SUBS_PER_BLOCK);
  localparam int SUB_W       = (SUBS_PER_BLOCK > 1) ? $clog2(SUBS_PER_BLOCK) : 1;
  localparam int FIRST_DEPTH = RING_BLOCKS * SUBS_PER_BLOCK;
  localparam int FIRST_AW    = $clog2(FIRST_DEPTH);

  localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};
  localparam logic [RUN_W-1:0]  RUN_MAX    = {RUN_W{1'b1}};
  localparam logic [JUMP_W-1:0] JUMP_RESET = JUMP_W'(64);
  localparam logic [RUN_W-1:0]  RUN_RESET  = RUN_W'(5);

  localparam logic [CFG_IDX_W-1:0] REG_MAX_JUMP    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BAD_RUN = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    KIND_DROP_ALIGN = 2'd0,
    KIND_DROP_SEQ   = 2'd1,
    KIND_PLACED     = 2'd2,
    KIND_FLUSH      = 2'd3
  } kind_e;

  typedef struct packed {
    logic [JUMP_W-1:0] max_count_jump;
    logic [RUN_W-1:0]  max_bad_run;
  } cfg_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq_count;
    logic [ENG_W-1:0] source_engine;
  } in_t;

  typedef struct packed {
    kind_e                kind;
    logic [IDX_OUT_W-1:0] block_index;
    logic [IDX_OUT_W-1:0] sub_block_index;
    logic [ENG_W-1:0]     engine_out;
    logic                 opened_block;
    logic                 opened_sub_block;
    logic                 block_complete;
    logic [SEQ_W-1:0]     first_count;
    logic [CNT_W-1:0]     flushed_packets;
    logic [MISS_W-1:0]    missed_total;
    logic                 resync;
    logic                 last;
  } out_t;

endpackage

`default_nettype wire

// ===== src/pbs_ram.sv =====
`default_nettype none

module pbs_ram #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/pbs_seq.sv =====
`default_nettype none
`include "assert_macros.svh"

module pbs_seq import pbs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output out_t      res_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EVAL   = 7'b0000010,
    S_FL_CHK = 7'b0000100,
    S_JUMP   = 7'b0001000,
    S_PLACE  = 7'b0010000,
    S_TAIL   = 7'b0100000,
    S_CPL_FL = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic                   synced_q, synced_d;
  logic [SEQ_W-1:0]       start_q, start_d;
  logic [SEQ_W-1:0]       prior_q, prior_d;
  logic [RUN_W-1:0]       bad_run_q, bad_run_d;
  logic [BLK_W-1:0]       cur_blk_q, cur_blk_d;
  logic [MISS_W-1:0]      missed_q, missed_d;
  logic [BLK_W-1:0]       idx_q, idx_d;
  logic [RING_BLOCKS-1:0] cvalid_q, cvalid_d;
  logic [RING_BLOCKS-1:0][SUBS_PER_BLOCK-1:0] svalid_q, svalid_d;

  logic [SEQ_W-1:0] seq_q, seq_d;
  logic [ENG_W-1:0] eng_q, eng_d;
  logic [SEQ_W-1:0] diff_q, diff_d;
  logic [BLK_W-1:0] blk_q, blk_d;
  logic [SUB_W-1:0] sub_q, sub_d;
  logic             cp_q, cp_d;
  out_t             plc_q, plc_d;

  // Count memory and sub-block first-count memory
  logic                cnt_we, cnt_re;
  logic [BLK_W-1:0]    cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]    cnt_wdata, cnt_rdata;
  logic                first_we, first_re;
  logic [FIRST_AW-1:0] first_waddr, first_raddr;
  logic [SEQ_W-1:0]    first_rdata;

  pbs_ram #(.DEPTH(RING_BLOCKS), .WIDTH(CNT_W)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  pbs_ram #(.DEPTH(FIRST_DEPTH), .WIDTH(SEQ_W)) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (first_we),
    .waddr_i (first_waddr),
    .wdata_i (seq_q),
    .re_i    (first_re),
    .raddr_i (first_raddr),
    .rdata_o (first_rdata)
  );

  function automatic out_t flush_res(input logic [BLK_W-1:0] blk,
                                     input logic [CNT_W-1:0] got,
                                     input logic [MISS_W-1:0] miss,
                                     input logic lst);
    out_t r;
    r                 = '0;
    r.kind            = KIND_FLUSH;
    r.block_index     = IDX_OUT_W'(blk);
    r.flushed_packets = got;
    r.missed_total    = miss;
    r.last            = lst;
    return r;
  endfunction

  // Datapath terms
  logic [SEQ_W-1:0]    diff_now, offset;
  logic                aligned, far;
  logic [BLK_W-1:0]    blk_now, back;
  logic [SUB_W-1:0]    sub_now;
  logic [RUN_W-1:0]    bad_inc;
  logic                bad_over;
  logic [CNT_W-1:0]    got_idx, got_back, flush_got, cnt_cur, cnt_new;
  logic [MISS_W-1:0]   miss_next;
  logic                ob, os, cp;
  logic [SEQ_W-1:0]    fc;
  logic [FIRST_AW-1:0] ent;

  assign diff_now  = (seq_q >= prior_q) ? seq_q - prior_q : prior_q - seq_q;
  assign aligned   = (seq_q % SEQ_W'(SUBS_PER_BLOCK)) == '0;
  assign far       = diff_q > SEQ_W'(cfg_i.max_count_jump);
  assign offset    = seq_q - start_q;
  assign blk_now   = BLK_W'(offset >> SUB_SH);
  assign sub_now   = SUB_W'(offset % SEQ_W'(SUBS_PER_BLOCK));
  assign bad_inc   = (bad_run_q == RUN_MAX) ? bad_run_q : bad_run_q + RUN_W'(1);
  assign bad_over  = bad_inc > cfg_i.max_bad_run;
  assign back      = (blk_q >= BLK_W'(2)) ? blk_q - BLK_W'(2)
                                          : blk_q + BLK_W'(RING_BLOCKS - 2);
  assign got_idx   = cvalid_q[idx_q] ? cnt_rdata : '0;
  assign got_back  = (cp_q && cvalid_q[back]) ? cnt_rdata : '0;
  assign flush_got = (state_q == S_CPL_FL) ? got_back : got_idx;
  assign miss_next = missed_q + MISS_W'(PACKETS_PER_BLOCK) - MISS_W'(flush_got);

  assign ent     = FIRST_AW'(blk_q * SUBS_PER_BLOCK + sub_q);
  assign cnt_cur = cvalid_q[blk_q] ? cnt_rdata : '0;
  assign ob      = cnt_cur == '0;
  assign os      = ob || !svalid_q[blk_q][sub_q];
  assign cnt_new = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + CNT_W'(1);
  assign cp      = cnt_new == CNT_W'(PACKETS_PER_BLOCK);

  // Sub-block 0 count: this packet, zero for a freshly opened block or an unseen sub-block 0, or memory
  always_comb begin
    if (sub_q == '0 && os) begin
      fc = seq_q;
    end else if (ob || !svalid_q[blk_q][0]) begin
      fc = '0;
    end else begin
      fc = first_rdata;
    end
  end

  always_comb begin
    logic adv;
    adv         = 1'b0;
    state_d     = state_q;
    synced_d    = synced_q;
    start_d     = start_q;
    prior_d     = prior_q;
    bad_run_d   = bad_run_q;
    cur_blk_d   = cur_blk_q;
    missed_d    = missed_q;
    idx_d       = idx_q;
    cvalid_d    = cvalid_q;
    svalid_d    = svalid_q;
    seq_d       = seq_q;
    eng_d       = eng_q;
    diff_d      = diff_q;
    blk_d       = blk_q;
    sub_d       = sub_q;
    cp_d        = cp_q;
    plc_d       = plc_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    cnt_we      = 1'b0;
    cnt_waddr   = blk_q;
    cnt_wdata   = cnt_new;
    cnt_re      = 1'b0;
    cnt_raddr   = idx_q;
    first_we    = 1'b0;
    first_waddr = ent;
    first_re    = 1'b0;
    first_raddr = FIRST_AW'(blk_now * SUBS_PER_BLOCK);

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          seq_d   = in_data_i.seq_count;
          eng_d   = in_data_i.source_engine;
          state_d = S_EVAL;
        end
      end

      S_EVAL: begin
        diff_d = diff_now;
        if (synced_q) begin
          state_d = S_JUMP;
        end else if (!aligned) begin
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_DROP_ALIGN;
          res_o.engine_out   = eng_q;
          res_o.missed_total = missed_q;
          res_o.last         = 1'b1;
          if (res_ready_i) begin
            state_d = S_IDLE;
          end
        end else begin
          // Start the restart scan over the ring
          cnt_re    = 1'b1;
          cnt_raddr = '0;
          idx_d     = '0;
          state_d   = S_FL_CHK;
        end
      end

      S_FL_CHK: begin
        if (idx_q == cur_blk_q) begin
          cvalid_d[idx_q] = 1'b0;
          adv             = 1'b1;
        end else if (got_idx != '0) begin
          res_valid_o = 1'b1;
          res_o       = flush_res(idx_q, got_idx, miss_next, 1'b0);
          if (res_ready_i) begin
            missed_d        = miss_next;
            cvalid_d[idx_q] = 1'b0;
            adv             = 1'b1;
          end
        end else begin
          adv = 1'b1;
        end
        if (adv) begin
          if (idx_q == BLK_W'(RING_BLOCKS - 1)) begin
            start_d   = seq_q - (SEQ_W'(cur_blk_q) << SUB_SH);
            prior_d   = seq_q;
            bad_run_d = '0;
            synced_d  = 1'b1;
            diff_d    = '0;
            state_d   = S_JUMP;
          end else begin
            idx_d     = idx_q + BLK_W'(1);
            cnt_re    = 1'b1;
            cnt_raddr = idx_q + BLK_W'(1);
          end
        end
      end

      S_JUMP: begin
        if (far) begin
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_DROP_SEQ;
          res_o.engine_out   = eng_q;
          res_o.missed_total = missed_q;
          res_o.resync       = bad_over;
          res_o.last         = 1'b1;
          if (res_ready_i) begin
            bad_run_d = bad_inc;
            if (bad_over) begin
              synced_d = 1'b0;
            end
            state_d = S_IDLE;
          end
        end else begin
          prior_d   = seq_q;
          bad_run_d = '0;
          blk_d     = blk_now;
          sub_d     = sub_now;
          cur_blk_d = blk_now;
          cnt_re    = 1'b1;
          cnt_raddr = blk_now;
          first_re  = 1'b1;
          state_d   = S_PLACE;
        end
      end

      S_PLACE: begin
        // Write back the count while fetching the block two places behind
        cnt_we          = 1'b1;
        cvalid_d[blk_q] = 1'b1;
        if (ob) begin
          svalid_d[blk_q] = '0;
        end
        svalid_d[blk_q][sub_q] = 1'b1;
        first_we               = os;
        plc_d                  = '0;
        plc_d.kind             = KIND_PLACED;
        plc_d.block_index      = IDX_OUT_W'(blk_q);
        plc_d.sub_block_index  = IDX_OUT_W'(sub_q);
        plc_d.engine_out       = eng_q;
        plc_d.opened_block     = ob;
        plc_d.opened_sub_block = os;
        plc_d.block_complete   = cp;
        plc_d.first_count      = cp ? fc : '0;
        plc_d.missed_total     = missed_q;
        cp_d                   = cp;
        cnt_re                 = 1'b1;
        cnt_raddr              = back;
        state_d                = S_TAIL;
      end

      S_TAIL: begin
        res_valid_o = 1'b1;
        res_o       = plc_q;
        res_o.last  = got_back == '0;
        if (res_ready_i) begin
          state_d = (got_back != '0) ? S_CPL_FL : S_IDLE;
        end
      end

      S_CPL_FL: begin
        res_valid_o = 1'b1;
        res_o       = flush_res(back, got_back, miss_next, 1'b1);
        if (res_ready_i) begin
          missed_d       = miss_next;
          cvalid_d[back] = 1'b0;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      synced_q  <= 1'b0;
      start_q   <= '0;
      prior_q   <= '0;
      bad_run_q <= '0;
      cur_blk_q <= '0;
      missed_q  <= '0;
      idx_q     <= '0;
      cvalid_q  <= '0;
      svalid_q  <= '0;
    end else begin
      state_q   <= state_d;
      synced_q  <= synced_d;
      start_q   <= start_d;
      prior_q   <= prior_d;
      bad_run_q <= bad_run_d;
      cur_blk_q <= cur_blk_d;
      missed_q  <= missed_d;
      idx_q     <= idx_d;
      cvalid_q  <= cvalid_d;
      svalid_q  <= svalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q  <= seq_d;
    eng_q  <= eng_d;
    diff_q <= diff_d;
    blk_q  <= blk_d;
    sub_q  <= sub_d;
    cp_q   <= cp_d;
    plc_q  <= plc_d;
  end

  `ASSERT_CLK(a_cnt_ports_apart, (cnt_we && cnt_re) |-> (cnt_waddr != cnt_raddr), "count memory read and write hit the same entry")
  `ASSERT_CLK(a_place_synced, (res_valid_o && res_o.kind == KIND_PLACED) |-> synced_q, "placed packet while not synchronized")
  `ASSERT_CLK(a_resync_clears, (res_valid_o && res_ready_i && res_o.resync) |=> !synced_q, "resync transfer left block synchronized")
  `ASSERT_CLK(a_missed_hold, !(res_valid_o && res_ready_i && res_o.kind == KIND_FLUSH) |=> $stable(missed_q), "missed total moved without a flush transfer")
  `ASSERT_NEVER(a_idle_quiet, in_ready_o && res_valid_o, "result offered while taking a new item")

endmodule

`default_nettype wire

// ===== src/packet_block_sequencer.sv =====
// Channel  Handshake                 Payload      Dir
// -------  ------------------------  -----------  ---
// in       in_valid_i / in_ready_o   in_data_i    in
// out      out_valid_o / out_ready_i out_data_o   out
// cfg      cfg_we_i                  cfg_index_i, cfg_data_i  in
//
// A placed packet passes accept, absolute jump, count memory read, count
// write-back with the lagging-block read, then the placed transfer.
// A drop is offered at the jump check, or at evaluation when unaligned; a
// completion flush adds a flush transfer, and a restart scans all RING_BLOCKS
// count entries, one per cycle while no flush transfer stalls, with its flush
// transfers taken inside the scan. One item is in flight.
// Reset clears per-entry valid bits at once; there is no clearing pass.
// A stalled output holds the result register and the sequencer waits on it.
`default_nettype none

module packet_block_sequencer import pbs_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_t                   in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_t                       out_data_o
);

  cfg_t cfg_q;
  logic out_valid_q;
  out_t out_data_q;
  logic res_valid, res_ready;
  out_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_count_jump <= JUMP_RESET;
      cfg_q.max_bad_run    <= RUN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MAX_JUMP:    cfg_q.max_count_jump <= cfg_data_i;
        REG_MAX_BAD_RUN: cfg_q.max_bad_run    <= cfg_data_i[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  pbs_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: load when empty or draining this cycle
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== sim/tb_packet_block_sequencer.sv =====
`default_nettype none

module tb_packet_block_sequencer;
  import pbs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 16;

  class ring_placement_scoreboard;
    cfg_t             regs;
    bit               is_synced;
    logic [SEQ_W-1:0] ring_start;
    logic [SEQ_W-1:0] last_good;
    logic [RUN_W-1:0] drop_run;
    int unsigned      cur_block;
    logic [CNT_W-1:0] pkt_count [RING_BLOCKS];
    logic [SEQ_W-1:0] first_seen [FIRST_DEPTH];
    bit               sub_seen [FIRST_DEPTH];
    logic [MISS_W-1:0] missed_acc;
    out_t             expected_results [$];
    int unsigned      errors;

    function new();
      regs.max_count_jump = JUMP_RESET;
      regs.max_bad_run    = RUN_RESET;
      is_synced  = 1'b0;
      ring_start = '0;
      last_good  = '0;
      drop_run   = '0;
      cur_block  = 0;
      missed_acc = '0;
      errors     = 0;
      foreach (pkt_count[i]) pkt_count[i] = '0;
      foreach (first_seen[i]) begin
        first_seen[i] = '0;
        sub_seen[i]   = 1'b0;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_MAX_JUMP) begin
        regs.max_count_jump = data;
      end else if (idx == REG_MAX_BAD_RUN) begin
        regs.max_bad_run = data[RUN_W-1:0];
      end
    endfunction

    // Emit a flush for an active block and add its shortfall to the running total.
    function void retire_block(int unsigned blk);
      out_t r;
      r = '0;
      if (pkt_count[blk] == '0) return;
      missed_acc = missed_acc + MISS_W'(PACKETS_PER_BLOCK) - MISS_W'(pkt_count[blk]);
      r.kind            = KIND_FLUSH;
      r.block_index     = IDX_OUT_W'(blk);
      r.flushed_packets = pkt_count[blk];
      r.missed_total    = missed_acc;
      pkt_count[blk]    = '0;
      expected_results.push_back(r);
    endfunction

    function void note_header(in_t hdr);
      out_t r;
      logic [SEQ_W-1:0] delta;
      logic [SEQ_W-1:0] offset;
      int unsigned blk, sub, base, k;
      r = '0;
      r.engine_out = hdr.source_engine;
      if (!is_synced) begin
        if ((hdr.seq_count % SUBS_PER_BLOCK) != 0) begin
          r.kind         = KIND_DROP_ALIGN;
          r.missed_total = missed_acc;
          r.last         = 1'b1;
          expected_results.push_back(r);
          return;
        end
        // Restart the ring at the current block; every other active block gets flushed.
        for (int unsigned i = 0; i < RING_BLOCKS; i++) begin
          if (i == cur_block) pkt_count[i] = '0;
          else retire_block(i);
        end
        ring_start = hdr.seq_count - SEQ_W'(cur_block * SUBS_PER_BLOCK);
        last_good  = hdr.seq_count;
        drop_run   = '0;
        is_synced  = 1'b1;
      end

      delta = (hdr.seq_count >= last_good) ? hdr.seq_count - last_good
                                           : last_good - hdr.seq_count;
      if (delta > SEQ_W'(regs.max_count_jump)) begin
        if (drop_run != RUN_MAX) drop_run = drop_run + 1'b1;
        r.kind = KIND_DROP_SEQ;
        if (drop_run > regs.max_bad_run) begin
          is_synced = 1'b0;
          r.resync  = 1'b1;
        end
        r.missed_total = missed_acc;
        r.last         = 1'b1;
        expected_results.push_back(r);
        return;
      end
      last_good = hdr.seq_count;
      drop_run  = '0;

      offset    = hdr.seq_count - ring_start;
      blk       = int'((offset / SUBS_PER_BLOCK) % RING_BLOCKS);
      sub       = int'(offset % SUBS_PER_BLOCK);
      base      = blk * SUBS_PER_BLOCK;
      cur_block = blk;
      r.kind            = KIND_PLACED;
      r.block_index     = IDX_OUT_W'(blk);
      r.sub_block_index = IDX_OUT_W'(sub);
      if (pkt_count[blk] == '0) begin
        for (int unsigned i = 0; i < SUBS_PER_BLOCK; i++) begin
          first_seen[base + i] = '0;
          sub_seen[base + i]   = 1'b0;
        end
        r.opened_block = 1'b1;
      end
      if (!sub_seen[base + sub]) begin
        sub_seen[base + sub]   = 1'b1;
        first_seen[base + sub] = hdr.seq_count;
        r.opened_sub_block     = 1'b1;
      end
      if (pkt_count[blk] != CNT_MAX) pkt_count[blk] = pkt_count[blk] + 1'b1;
      if (pkt_count[blk] == CNT_W'(PACKETS_PER_BLOCK)) begin
        r.block_complete = 1'b1;
        r.first_count    = sub_seen[base] ? first_seen[base] : '0;
      end
      r.missed_total = missed_acc;
      expected_results.push_back(r);
      if (r.block_complete) retire_block((blk + 2 * (RING_BLOCKS - 1)) % RING_BLOCKS);
      k = expected_results.size() - 1;
      expected_results[k].last = 1'b1;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("block_index", want.block_index, got.block_index);
      compare_field("sub_block_index", want.sub_block_index, got.sub_block_index);
      compare_field("engine_out", want.engine_out, got.engine_out);
      compare_field("opened_block", want.opened_block, got.opened_block);
      compare_field("opened_sub_block", want.opened_sub_block, got.opened_sub_block);
      compare_field("block_complete", want.block_complete, got.block_complete);
      compare_field("first_count", want.first_count, got.first_count);
      compare_field("flushed_packets", want.flushed_packets, got.flushed_packets);
      compare_field("missed_total", want.missed_total, got.missed_total);
      compare_field("resync", want.resync, got.resync);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_t                   in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_t                  out_data_o;

  ring_placement_scoreboard sb = new();
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;

  packet_block_sequencer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i) cycle_count++;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: rotate a stall pattern, picking a new one now and then.
  initial begin
    logic [7:0] pat;
    int unsigned hold;
    pat  = 8'hFF;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold == 0) begin
        hold = $urandom_range(20, 80);
        pat  = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(1, 254));
      end
      hold--;
      out_ready_i = pat[0];
      pat = {pat[0], pat[7:1]};
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  function automatic logic [SEQ_W-1:0] rand_count();
    return SEQ_W'({$urandom(), $urandom()});
  endfunction

  function automatic logic [SEQ_W-1:0] align_down(logic [SEQ_W-1:0] c);
    return c - (c % SUBS_PER_BLOCK);
  endfunction

  // Hold valid until the transfer, then maybe insert a gap between bursts.
  task automatic send(input logic [SEQ_W-1:0] seq, input logic [ENG_W-1:0] eng);
    in_t hdr;
    int unsigned gap;
    hdr.seq_count     = seq;
    hdr.source_engine = eng;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = hdr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_header(hdr);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic configure(input logic [JUMP_W-1:0] jump, input logic [RUN_W-1:0] run);
    wait_idle();
    write_reg(REG_MAX_JUMP, jump);
    write_reg(REG_MAX_BAD_RUN, CFG_DATA_W'(run));
  endtask

  // Push far-off counts until the bad-run limit drops synchronization.
  task automatic force_resync();
    while (sb.is_synced) send(sb.last_good ^ 48'h8000_0000_0000, 8'($urandom_range(0, 255)));
  endtask

  // Mostly in-order counts with several packets each, plus noise and jumps.
  task automatic run_stream(input int unsigned n_items);
    logic [SEQ_W-1:0] cur;
    logic [ENG_W-1:0] eng;
    int unsigned per, left, r;
    per  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20)
                                       : PACKETS_PER_BLOCK / SUBS_PER_BLOCK;
    left = per;
    cur  = sb.is_synced ? sb.last_good : align_down(rand_count());
    for (int unsigned i = 0; i < n_items; i++) begin
      eng = 8'($urandom_range(0, 255));
      r   = $urandom_range(0, 99);
      if (r < 5) begin
        send(rand_count(), eng);
      end else if (r < 7 && sb.regs.max_bad_run < 8) begin
        force_resync();
        cur  = align_down(rand_count());
        left = per;
      end else if (r < 13) begin
        send(cur - SEQ_W'($urandom_range(1, SUBS_PER_BLOCK)), eng);
      end else begin
        // Jump to an aligned count to restart cleanly after a lost sync.
        if (!sb.is_synced && (cur % SUBS_PER_BLOCK) != 0) begin
          cur  = align_down(cur) + SUBS_PER_BLOCK;
          left = per;
        end
        send(cur, eng);
        left = left - 1;
        if (left == 0) begin
          left = per;
          cur  = cur + (($urandom_range(0, 9) == 0) ? $urandom_range(2, SUBS_PER_BLOCK) : 1);
        end
      end
    end
  endtask

  initial begin
    logic [SEQ_W-1:0] base;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Unaligned starts, start at the top of the count range, jump boundary.
    send(48'h1, 8'hFF);
    send(48'hFFFF_FFFF_FFFF, 8'h00);
    send(48'hFFFF_FFFF_FFFC, 8'hA5);
    send(48'hFFFF_FFFF_FFFF, 8'h5A);
    send(48'hFFFF_FFFF_FFBF, 8'h01);
    send(48'hFFFF_FFFF_FFFF, 8'h80);
    // Wrap to zero is a jump, not an in-sequence step.
    send(48'h0, 8'h7F);
    send(48'hFFFF_FFFF_FFBE, 8'h02);
    send(48'h8000_0000_0000, 8'h04);
    send(48'h1, 8'h08);
    send(48'h2, 8'h10);
    send(48'h3, 8'h20);
    send(48'h6, 8'h40);
    send(48'h8, 8'h11);
    send(48'hC, 8'h22);
    send(48'hD, 8'h33);

    // Zero tolerance: a single step resyncs, restart from a later block wraps the start.
    configure(16'h0, 8'h0);
    send(48'hD, 8'h44);
    send(48'hE, 8'h55);
    send(48'h0, 8'h66);
    send(48'h0, 8'h77);
    send(48'h1, 8'h88);
    send(48'h4, 8'h99);

    // Widest limits: a long bad run without a resync.
    configure(16'hFFFF, 8'hFF);
    repeat (20) send(sb.last_good ^ 48'h8000_0000_0000, 8'($urandom_range(0, 255)));
    send(sb.last_good + 48'hFFFF, 8'hC3);

    // Overfill one block past its full mark, then flush it by a restart.
    configure(16'd64, 8'd3);
    force_resync();
    base = align_down(rand_count());
    repeat (PACKETS_PER_BLOCK + 13) send(base, 8'($urandom_range(0, 255)));
    repeat (3) send(base + SUBS_PER_BLOCK, 8'($urandom_range(0, 255)));
    force_resync();
    base = align_down(rand_count());
    send(base, 8'h3C);
    // Fill the next block without ever touching its first sub-block.
    repeat (PACKETS_PER_BLOCK) send(base + SUBS_PER_BLOCK + 1, 8'($urandom_range(0, 255)));

    for (int unsigned ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(16'd64, 8'd5);
        1: configure(16'd3, 8'd2);
        2: configure(16'hFFFF, 8'hFF);
        3: configure(16'd0, 8'd0);
        default: configure(16'($urandom_range(0, 80)), 8'($urandom_range(0, 8)));
      endcase
      run_stream(42);
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/pbs_pkg.sv
src/pbs_ram.sv
src/pbs_seq.sv
src/packet_block_sequencer.sv
sim/tb_packet_block_sequencer.sv
